FILE: src/ptod_pkg.sv
// ----------------------------------------------------------------------------
// ptod_pkg
// Shared types, codes and constants of the prescaled time-of-day clock.
// ----------------------------------------------------------------------------
package ptod_pkg;

  // Input item modes
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_ACK     = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELAPSED_THRESHOLD = 2'd2;

  // Register widths and reset values
  localparam int unsigned PERIOD_W = 17;
  localparam int unsigned TPMS_W   = 20;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned ELAPSED_W = 32;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 17'd1;
  localparam logic [TPMS_W-1:0]   TPMS_RST   = 20'd150000;

  // Counter tops
  localparam logic [9:0] MS_TOP   = 10'd999;
  localparam logic [5:0] SEC_TOP  = 6'd59;
  localparam logic [5:0] MIN_TOP  = 6'd59;
  localparam logic [4:0] HOUR_TOP = 5'd23;

  // Carry event bit positions
  localparam int unsigned EV_MS   = 0;
  localparam int unsigned EV_SEC  = 1;
  localparam int unsigned EV_MIN  = 2;
  localparam int unsigned EV_HOUR = 3;

  typedef struct packed {
    logic [1:0] mode;
    logic [9:0] set_millisecond;
    logic [5:0] set_second;
    logic [5:0] set_minute;
    logic [4:0] set_hour;
  } in_item_t;

  typedef struct packed {
    logic [9:0] millisecond_now;
    logic [5:0] second_now;
    logic [5:0] minute_now;
    logic [4:0] hour_now;
    logic [3:0] carry_events;
    logic       five_minute_alarm;
    logic       elapsed_over;
  } out_item_t;

  // Decoded command passed from the front to the back
  typedef struct packed {
    logic       tick;
    logic       load;
    logic       restart;
    logic       ack;
    logic [9:0] millisecond;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } cmd_t;

  // True for minute values 0, 5, 10, ... 60
  function automatic logic is_mult_of_five(input logic [5:0] v);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 13; k++) begin
      if (v == 6'(5 * k)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

FILE: src/ptod_in_if.sv
// ----------------------------------------------------------------------------
// ptod_in_if
// Input channel of the time-of-day clock: valid, ready and one input item.
// ----------------------------------------------------------------------------
interface ptod_in_if;
  import ptod_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/ptod_out_if.sv
// ----------------------------------------------------------------------------
// ptod_out_if
// Result channel of the time-of-day clock: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface ptod_out_if;
  import ptod_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/ptod_front.sv
// ----------------------------------------------------------------------------
// ptod_front
// Accept input items and decode the mode into a one-hot command.
// ----------------------------------------------------------------------------
module ptod_front (
  ptod_in_if.sink         in_i,
  input  logic            q_full_i,
  output logic            push_o,
  output ptod_pkg::cmd_t  push_cmd_o
);
  import ptod_pkg::*;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  always_comb begin
    push_cmd_o             = '0;
    push_cmd_o.millisecond = in_i.payload.set_millisecond;
    push_cmd_o.second      = in_i.payload.set_second;
    push_cmd_o.minute      = in_i.payload.set_minute;
    push_cmd_o.hour        = in_i.payload.set_hour;
    case (in_i.payload.mode)
      MODE_TICK:    push_cmd_o.tick    = 1'b1;
      MODE_LOAD:    push_cmd_o.load    = 1'b1;
      MODE_RESTART: push_cmd_o.restart = 1'b1;
      MODE_ACK:     push_cmd_o.ack     = 1'b1;
      default:      push_cmd_o.tick    = 1'b1;
    endcase
  end

endmodule

FILE: src/ptod_queue.sv
// ----------------------------------------------------------------------------
// ptod_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module ptod_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ptod_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output ptod_pkg::cmd_t head_o
);
  import ptod_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o       = (cnt_q == CntW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !do_pop |=> cnt_q == CntW'(DEPTH))
    else $error("queue lost an entry while full");

endmodule

FILE: src/ptod_back.sv
// ----------------------------------------------------------------------------
// ptod_back
// Execute commands: accumulator, time cascade, alarm, elapsed count, result.
// ----------------------------------------------------------------------------
module ptod_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ptod_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ptod_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                head_valid_i,
  input  ptod_pkg::cmd_t                      head_i,
  output logic                                pop_o,
  ptod_out_if.source                          out_o
);
  import ptod_pkg::*;

  logic [PERIOD_W-1:0]  period_q;
  logic [TPMS_W-1:0]    tpms_q;
  logic [ELAPSED_W-1:0] thresh_q;

  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [9:0]           ms_q, ms_d;
  logic [5:0]           sec_q, sec_d;
  logic [5:0]           min_q, min_d;
  logic [4:0]           hour_q, hour_d;
  logic                 alarm_q, alarm_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [3:0]           ev_q, ev_d;
  logic                 over_d;

  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q;

  logic [ACC_W-1:0]     acc_sum;
  logic                 adv;
  logic [9:0]           ms_inc;
  logic [5:0]           sec_inc;
  logic [5:0]           min_inc;
  logic [4:0]           hour_inc;

  assign pop_o         = head_valid_i && (!out_valid_q || out_o.ready);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Accumulate and test against one millisecond worth of ticks
  assign acc_sum  = acc_q + ACC_W'(period_q);
  assign adv      = head_i.tick && (acc_sum >= ACC_W'(tpms_q));
  assign ms_inc   = ms_q + 10'd1;
  assign sec_inc  = sec_q + 6'd1;
  assign min_inc  = min_q + 6'd1;
  assign hour_inc = hour_q + 5'd1;

  always_comb begin
    acc_d     = acc_q;
    ms_d      = ms_q;
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    alarm_d   = alarm_q;
    elapsed_d = elapsed_q;
    ev_d      = ev_q;
    over_d    = (elapsed_q > thresh_q);

    if (head_i.tick) begin
      acc_d = adv ? acc_sum - ACC_W'(tpms_q) : acc_sum;
      ev_d  = '0;
    end

    if (adv) begin
      ev_d[EV_MS] = 1'b1;
      elapsed_d   = elapsed_q + ELAPSED_W'(1);
      // e + 1 > th, without a second adder in the path
      over_d      = (elapsed_q >= thresh_q) && !(&elapsed_q);
      ms_d        = ms_inc;
      if (ms_inc > MS_TOP) begin
        ms_d         = '0;
        ev_d[EV_SEC] = 1'b1;
        sec_d        = sec_inc;
        if (sec_inc > SEC_TOP) begin
          sec_d        = '0;
          ev_d[EV_MIN] = 1'b1;
          min_d        = min_inc;
          if (min_inc > MIN_TOP) begin
            min_d         = '0;
            ev_d[EV_HOUR] = 1'b1;
            hour_d        = (hour_inc > HOUR_TOP) ? '0 : hour_inc;
          end
          if (is_mult_of_five(min_d)) alarm_d = 1'b1;
        end
      end
    end

    if (head_i.load) begin
      ms_d   = head_i.millisecond;
      sec_d  = head_i.second;
      min_d  = head_i.minute;
      hour_d = head_i.hour;
    end
    if (head_i.restart) begin
      elapsed_d = '0;
      over_d    = 1'b0;
    end
    if (head_i.ack) begin
      alarm_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      tpms_q   <= TPMS_RST;
      thresh_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PERIOD_TICKS:      period_q <= cfg_data_i[PERIOD_W-1:0];
        REG_TICKS_PER_MS:      tpms_q   <= cfg_data_i[TPMS_W-1:0];
        REG_ELAPSED_THRESHOLD: thresh_q <= cfg_data_i[ELAPSED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ms_q        <= '0;
      sec_q       <= '0;
      min_q       <= '0;
      hour_q      <= '0;
      alarm_q     <= 1'b0;
      elapsed_q   <= '0;
      ev_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        acc_q     <= acc_d;
        ms_q      <= ms_d;
        sec_q     <= sec_d;
        min_q     <= min_d;
        hour_q    <= hour_d;
        alarm_q   <= alarm_d;
        elapsed_q <= elapsed_d;
        ev_q      <= ev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.millisecond_now   <= ms_d;
      out_q.second_now        <= sec_d;
      out_q.minute_now        <= min_d;
      out_q.hour_now          <= hour_d;
      out_q.carry_events      <= ev_d;
      out_q.five_minute_alarm <= alarm_q;
      out_q.elapsed_over      <= over_d;
    end
  end

  a_carry_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ev_q[EV_HOUR] || ev_q[EV_MIN]) && (!ev_q[EV_MIN] || ev_q[EV_SEC])
    && (!ev_q[EV_SEC] || ev_q[EV_MS]))
    else $error("carry event without the lower carry");

  a_ack_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.ack |=> !alarm_q)
    else $error("acknowledge left the alarm set");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(acc_q) && $stable(elapsed_q) && $stable(ms_q))
    else $error("state moved without a command");

endmodule

FILE: src/prescaled_time_of_day_clock_core.sv
// ----------------------------------------------------------------------------
// prescaled_time_of_day_clock_core
// Time-of-day clock driven by periodic tick items, with elapsed-time counter.
// ----------------------------------------------------------------------------
// The block takes one input item per clock cycle while the command queue has
// room, and gives exactly one result per item, in order. An accepted item is
// written into the command queue, then executed into the output register,
// where its result sits until it is taken; the input keeps flowing while it
// waits, until the command queue fills. The rate of one item per cycle is set
// by the execute unit, which does the accumulator add and the millisecond
// compare combinationally. A tick item adds period_ticks to
// the accumulator and advances at most one millisecond, cascading through
// seconds, minutes and hours; carry_events reports which counters advanced on
// the most recent tick. five_minute_alarm is the sticky alarm as it stood
// before the item, and elapsed_over compares the elapsed count after the item
// with the threshold. Write configuration registers only while the block is
// idle; there is no memory and no clearing pass after reset.
// ----------------------------------------------------------------------------
module prescaled_time_of_day_clock_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ptod_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptod_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  ptod_in_if.sink                          in_i,
  ptod_out_if.source                       out_o
);
  import ptod_pkg::*;

  // Front to queue
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // Queue to back
  logic head_valid;
  cmd_t head;
  logic pop;

  // Accept and decode each transfer on the input channel
  ptod_front u_front (
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // Hold decoded commands so either side can stall on its own
  ptod_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Advance the clock state and register one result per command
  ptod_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
